[hw/rtl/rfr_pkg.sv]
// Package: shared types, constants and the CRC-16 byte update of the frame receiver.
`default_nettype none

package rfr_pkg;

  localparam int unsigned StoreDepth = 14;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  LimitReset = 8'd255;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_LEN_REJ = 2'd2
  } rfr_status_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PAYLOAD = 2'd1,
    ST_CRC_LO  = 2'd2,
    ST_CRC_HI  = 2'd3
  } rfr_state_e;

  typedef struct packed {
    logic [31:0] node_id;
    logic [15:0] battery_level;
    logic [7:0]  sense_flags;
    logic [23:0] count_a;
    logic [23:0] count_b;
    logic [7:0]  packet_number;
  } rfr_record_t;

  typedef struct packed {
    rfr_status_e status;
    logic [7:0]  payload_length;
    rfr_record_t record;
  } rfr_result_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rfr_rx_if.sv]
// Interface: received byte channel with valid/ready handshake.
`default_nettype none

interface rfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/rfr_res_if.sv]
// Interface: frame result channel with valid/ready handshake.
`default_nettype none

interface rfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  payload_length;
  logic [31:0] node_id;
  logic [15:0] battery_level;
  logic [7:0]  sense_flags;
  logic [23:0] count_a;
  logic [23:0] count_b;
  logic [7:0]  packet_number;

  modport source (
    output valid, output status, output payload_length, output node_id,
    output battery_level, output sense_flags, output count_a, output count_b,
    output packet_number, input ready
  );
  modport sink (
    input valid, input status, input payload_length, input node_id,
    input battery_level, input sense_flags, input count_a, input count_b,
    input packet_number, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/rfr_frame_parser.sv]
// Module: frame parser with length check, CRC update, field store and held record.
`default_nettype none

module rfr_frame_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic [7:0]          limit_i,
  output logic                     emit_o,
  output rfr_pkg::rfr_result_t     result_o
);

  rfr_pkg::rfr_state_e state_q, state_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  store_q [rfr_pkg::StoreDepth];
  logic [7:0]  store_v [rfr_pkg::StoreDepth];
  rfr_pkg::rfr_record_t rec_q, rec_d, rec_new;
  logic        len_ok;
  logic        store_we;
  logic        crc_match;

  assign len_ok    = (byte_i != 8'd0) && (byte_i < limit_i);
  assign store_we  = accept_i && (state_q != rfr_pkg::ST_IDLE) &&
                     ({1'b0, count_q} < 9'(rfr_pkg::StoreDepth));
  assign crc_match = ({byte_i, low_q} == crc_q);

  // Store contents as they stand after this byte is written.
  always_comb begin
    for (int i = 0; i < rfr_pkg::StoreDepth; i++) begin
      store_v[i] = store_q[i];
      if (store_we && (count_q[rfr_pkg::StoreAw-1:0] == rfr_pkg::StoreAw'(i))) begin
        store_v[i] = byte_i;
      end
    end
  end

  always_comb begin
    rec_new.node_id       = {store_v[3], store_v[2], store_v[1], store_v[0]};
    rec_new.battery_level = {store_v[5], store_v[4]};
    rec_new.sense_flags   = store_v[6];
    rec_new.count_a       = {store_v[9], store_v[8], store_v[7]};
    rec_new.count_b       = {store_v[12], store_v[11], store_v[10]};
    rec_new.packet_number = store_v[13];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      unique case (state_q)
        rfr_pkg::ST_IDLE: begin
          if (len_ok) state_d = rfr_pkg::ST_PAYLOAD;
        end
        rfr_pkg::ST_PAYLOAD: begin
          if (count_q + 8'd1 == len_q) state_d = rfr_pkg::ST_CRC_LO;
        end
        rfr_pkg::ST_CRC_LO: state_d = rfr_pkg::ST_CRC_HI;
        rfr_pkg::ST_CRC_HI: state_d = rfr_pkg::ST_IDLE;
        default:            state_d = rfr_pkg::ST_IDLE;
      endcase
    end
  end

  // Datapath and result outputs.
  always_comb begin
    len_d   = len_q;
    count_d = count_q;
    crc_d   = crc_q;
    low_d   = low_q;
    rec_d   = rec_q;
    emit_o  = 1'b0;
    result_o.status         = rfr_pkg::STATUS_GOOD;
    result_o.payload_length = len_q;
    if (accept_i) begin
      unique case (state_q)
        rfr_pkg::ST_IDLE: begin
          if (len_ok) begin
            len_d   = byte_i;
            count_d = 8'd0;
            crc_d   = rfr_pkg::CrcInit;
          end else begin
            emit_o                  = 1'b1;
            result_o.status         = rfr_pkg::STATUS_LEN_REJ;
            result_o.payload_length = byte_i;
          end
        end
        rfr_pkg::ST_PAYLOAD: begin
          crc_d   = rfr_pkg::crc16_byte(crc_q, byte_i);
          count_d = count_q + 8'd1;
        end
        rfr_pkg::ST_CRC_LO: begin
          low_d   = byte_i;
          count_d = count_q + 8'd1;
        end
        rfr_pkg::ST_CRC_HI: begin
          emit_o  = 1'b1;
          count_d = 8'd0;
          crc_d   = rfr_pkg::CrcInit;
          if (crc_match) begin
            rec_d           = rec_new;
            result_o.status = rfr_pkg::STATUS_GOOD;
          end else begin
            result_o.status = rfr_pkg::STATUS_CRC_ERR;
          end
        end
        default: begin
          count_d = 8'd0;
        end
      endcase
    end
    result_o.record = rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfr_pkg::ST_IDLE;
      len_q   <= 8'd0;
      count_q <= 8'd0;
      crc_q   <= rfr_pkg::CrcInit;
      low_q   <= 8'd0;
      rec_q   <= '0;
      for (int i = 0; i < rfr_pkg::StoreDepth; i++) begin
        store_q[i] <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      low_q   <= low_d;
      rec_q   <= rec_d;
      for (int i = 0; i < rfr_pkg::StoreDepth; i++) begin
        store_q[i] <= store_v[i];
      end
    end
  end

  // A frame end always returns to idle with a fresh CRC.
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (state_q == rfr_pkg::ST_CRC_HI) |=>
      (state_q == rfr_pkg::ST_IDLE) && (crc_q == rfr_pkg::CrcInit) && (count_q == 8'd0))
    else $error("frame end did not return to idle");

  // The payload count never reaches the frame length while in the payload phase.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfr_pkg::ST_PAYLOAD) |-> (count_q < len_q))
    else $error("payload count out of range");

  // The held record only changes on a good frame end.
  a_record_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_o && (result_o.status == rfr_pkg::STATUS_GOOD)) |=> $stable(rec_q))
    else $error("record changed without a good frame");

endmodule

`default_nettype wire

[hw/rtl/rfr_result_reg.sv]
// Module: one-word output register between the parser and the result channel.
`default_nettype none

module rfr_result_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire rfr_pkg::rfr_result_t data_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output rfr_pkg::rfr_result_t      data_o,
  output logic                      can_load_o
);

  logic                 valid_q, valid_d;
  rfr_pkg::rfr_result_t data_q;

  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign data_o      = data_q;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/radio_frame_receiver_crc_check.sv]
// Top level: length-prefixed radio frame receiver with CRC-16 check and telemetry record.
// Registered result: valid in the cycle after the byte that ends or rejects a frame.
// Throughput: one byte per cycle unless ready drops; one unrolled CRC-16 update per byte.
// Input ready drops only while a finished result word waits and the sink is not ready.
// Reset (rst_ni low, asynchronous): receiver idle, CRC 0xFFFF, field store and record
// cleared, length limit 255, no result pending.
`default_nettype none

module radio_frame_receiver_crc_check (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  rfr_rx_if.sink          rx_i,
  rfr_res_if.source       res_o
);

  // Length limit: the user writes it only while the receiver is idle; not enforced.
  logic [7:0] limit_q;

  logic                 accept;
  logic                 emit;
  logic                 can_load;
  rfr_pkg::rfr_result_t parse_result;
  rfr_pkg::rfr_result_t out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rfr_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // A byte is taken whenever the output register is empty or being drained, so a
  // finished result never blocks the byte stream unless the sink itself stalls.
  assign rx_i.ready = can_load;
  assign accept     = rx_i.valid && can_load;

  // The parser does all work for one byte in a single pass: length check, CRC
  // update, store write and record refresh at the final CRC byte.
  rfr_frame_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (rx_i.rx_byte),
    .limit_i  (limit_q),
    .emit_o   (emit),
    .result_o (parse_result)
  );

  // The output register holds one result word until the sink takes it.
  rfr_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .data_i      (parse_result),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .data_o      (out_result),
    .can_load_o  (can_load)
  );

  assign res_o.status         = out_result.status;
  assign res_o.payload_length = out_result.payload_length;
  assign res_o.node_id        = out_result.record.node_id;
  assign res_o.battery_level  = out_result.record.battery_level;
  assign res_o.sense_flags    = out_result.record.sense_flags;
  assign res_o.count_a        = out_result.record.count_a;
  assign res_o.count_b        = out_result.record.count_b;
  assign res_o.packet_number  = out_result.record.packet_number;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for the length-prefixed radio frame receiver: directed, limit, random and stall tests.
`default_nettype none

module tb_top;

  // A result word is registered and shows up in the cycle after the byte that causes it.
  // Extra margin is allowed before a limit write and at the end of the run.
  localparam int SettleCycles  = 4;
  // Length of the long receiver hold-off in the stall test.
  localparam int HoldOffCycles = 100;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  rfr_rx_if  rx ();
  rfr_res_if res ();

  radio_frame_receiver_crc_check DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx),
    .res_o       (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Inputs of the block are known from time zero.
  initial begin
    rx.valid   = 1'b0;
    rx.rx_byte = 8'd0;
    res.ready  = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predicted receiver state. It follows every accepted byte and mirrors what the block
  // should hold: the frame position, the running CRC, the 14-byte field store and the
  // telemetry record that a good frame refreshes.
  // ---------------------------------------------------------------------------------------
  logic [7:0]           length_limit_q;
  bit                   in_frame_q;
  logic [7:0]           frame_len_q;
  logic [8:0]           frame_pos_q;
  logic [15:0]          frame_crc_q;
  logic [7:0]           crc_low_q;
  logic [7:0]           field_store_q [rfr_pkg::StoreDepth];
  rfr_pkg::rfr_record_t telemetry_q;

  // Result words that the receiver still owes, oldest first.
  rfr_pkg::rfr_result_t pending_words_q[$];

  int errors     = 0;
  int n_bytes    = 0;
  int n_good     = 0;
  int n_crc_bad  = 0;
  int n_rejected = 0;
  int n_limits   = 0;
  int n_checked  = 0;

  // Idle control for the two sides, and the request for a long hold-off on the result side.
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  bit hold_req = 1'b0;

  // CRC-16 with polynomial 0x1021, fed one data bit at a time, most significant bit first.
  function automatic logic [15:0] crc16_ccitt_next(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    logic        feedback;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      feedback = c[15] ^ data[i];
      c = {c[14:0], 1'b0};
      if (feedback) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  task automatic clear_receiver_model();
    length_limit_q = rfr_pkg::LimitReset;
    in_frame_q     = 1'b0;
    frame_len_q    = 8'd0;
    frame_pos_q    = 9'd0;
    frame_crc_q    = rfr_pkg::CrcInit;
    crc_low_q      = 8'd0;
    telemetry_q    = '0;
    foreach (field_store_q[i]) field_store_q[i] = 8'd0;
  endtask

  // Advances the predicted receiver by one accepted byte and queues the result word, if any.
  task automatic predict_rx_byte(input logic [7:0] b);
    rfr_pkg::rfr_result_t word;
    bit                   ends_frame;
    word       = '0;
    ends_frame = 1'b0;
    if (!in_frame_q) begin
      // While idle the byte is a length: zero and anything at or above the limit is refused.
      if (b != 8'd0 && b < length_limit_q) begin
        in_frame_q  = 1'b1;
        frame_len_q = b;
        frame_pos_q = 9'd0;
        frame_crc_q = rfr_pkg::CrcInit;
      end else begin
        word.status         = rfr_pkg::STATUS_LEN_REJ;
        word.payload_length = b;
        ends_frame          = 1'b1;
        n_rejected++;
      end
    end else begin
      // Payload and CRC bytes alike land in the store while their position is below 14.
      if (frame_pos_q < rfr_pkg::StoreDepth) field_store_q[frame_pos_q] = b;
      if (frame_pos_q < {1'b0, frame_len_q}) begin
        frame_crc_q = crc16_ccitt_next(frame_crc_q, b);
        frame_pos_q = frame_pos_q + 9'd1;
      end else if (frame_pos_q == {1'b0, frame_len_q}) begin
        crc_low_q   = b;
        frame_pos_q = frame_pos_q + 9'd1;
      end else begin
        if ({b, crc_low_q} == frame_crc_q) begin
          // The record is read after the high CRC byte has been stored, so short frames
          // pick up CRC bytes and stale bytes of older frames.
          telemetry_q.node_id       = {field_store_q[3], field_store_q[2],
                                       field_store_q[1], field_store_q[0]};
          telemetry_q.battery_level = {field_store_q[5], field_store_q[4]};
          telemetry_q.sense_flags   = field_store_q[6];
          telemetry_q.count_a       = {field_store_q[9], field_store_q[8], field_store_q[7]};
          telemetry_q.count_b       = {field_store_q[12], field_store_q[11],
                                       field_store_q[10]};
          telemetry_q.packet_number = field_store_q[13];
          word.status = rfr_pkg::STATUS_GOOD;
          n_good++;
        end else begin
          word.status = rfr_pkg::STATUS_CRC_ERR;
          n_crc_bad++;
        end
        word.payload_length = frame_len_q;
        in_frame_q          = 1'b0;
        frame_pos_q         = 9'd0;
        frame_crc_q         = rfr_pkg::CrcInit;
        ends_frame          = 1'b1;
      end
    end
    if (ends_frame) begin
      word.record = telemetry_q;
      pending_words_q.push_back(word);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Byte sender. It is entered and left just after a falling edge. Valid stays high after
  // a word is taken, so back-to-back bytes never drop it; lower_valid ends a burst.
  // ---------------------------------------------------------------------------------------
  task automatic send_rx_byte(input logic [7:0] b);
    while (tx_gaps && $urandom_range(0, 99) < 15) begin
      rx.valid   = 1'b0;
      rx.rx_byte = 8'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    rx.valid   = 1'b1;
    rx.rx_byte = b;
    @(posedge clk_i);
    while (!rx.ready) @(posedge clk_i);
    predict_rx_byte(b);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic lower_valid();
    rx.valid   = 1'b0;
    rx.rx_byte = 8'($urandom_range(0, 255));
  endtask

  // Sends length, payload and CRC. Bits set in crc_flip corrupt the CRC on the wire, so
  // the low byte, the high byte or both can be made wrong.
  task automatic send_frame(input logic [7:0] body[$], input logic [15:0] crc_flip);
    logic [15:0] crc;
    crc = rfr_pkg::CrcInit;
    send_rx_byte(8'(body.size()));
    foreach (body[i]) begin
      crc = crc16_ccitt_next(crc, body[i]);
      send_rx_byte(body[i]);
    end
    crc = crc ^ crc_flip;
    send_rx_byte(crc[7:0]);
    send_rx_byte(crc[15:8]);
  endtask

  task automatic send_random_frame(input int len, input bit corrupt);
    logic [7:0] body[$];
    logic [15:0] flip;
    int          i;
    for (i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    flip = corrupt ? 16'(1 << $urandom_range(0, 15)) : 16'h0000;
    send_frame(body, flip);
  endtask

  // Brings the receiver to rest: any frame in progress is completed with random bytes,
  // every owed word is collected, and then a settling margin passes.
  task automatic settle_receiver();
    while (in_frame_q) send_rx_byte(8'($urandom_range(0, 255)));
    lower_valid();
    while (pending_words_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_length_limit(input logic [7:0] value);
    settle_receiver();
    cfg_we_i       = 1'b1;
    cfg_wdata_i    = value;
    length_limit_q = value;
    n_limits++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side. Ready changes at the falling edge; a requested hold-off keeps it low until
  // the hold_left countdown runs out, while the sender keeps offering bytes.
  // ---------------------------------------------------------------------------------------
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready = 1'b0;
    end else begin
      res.ready = !rx_gaps || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s differs, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Each accepted result word is compared with the oldest owed word.
  always @(posedge clk_i) begin
    rfr_pkg::rfr_result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_words_q.size() == 0) begin
        $display("%0t: unexpected result word, status %0d length %0d", $time,
                 res.status, res.payload_length);
        errors++;
      end else begin
        want = pending_words_q.pop_front();
        n_checked++;
        check_field("status", 32'(want.status), 32'(res.status));
        check_field("payload_length", 32'(want.payload_length), 32'(res.payload_length));
        check_field("node_id", want.record.node_id, res.node_id);
        check_field("battery_level", 32'(want.record.battery_level),
                    32'(res.battery_level));
        check_field("sense_flags", 32'(want.record.sense_flags), 32'(res.sense_flags));
        check_field("count_a", 32'(want.record.count_a), 32'(res.count_a));
        check_field("count_b", 32'(want.record.count_b), 32'(res.count_b));
        check_field("packet_number", 32'(want.record.packet_number),
                    32'(res.packet_number));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Zero length, a length at the reset limit, one-byte frames with good and bad CRCs, all-zero
  // and all-one payload bytes, and a wrong high CRC byte with a right low byte.
  task automatic test_directed();
    logic [7:0] body[$];
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    body = {8'h00};
    send_frame(body, 16'h0000);
    body = {8'hFF};
    send_frame(body, 16'h0001);
    body = {8'h00, 8'hFF};
    send_frame(body, 16'h0000);
    body = {8'hA5, 8'h5A, 8'h3C};
    send_frame(body, 16'h8000);
    settle_receiver();
  endtask

  // Limits of zero and one refuse every length; a limit of two leaves only one-byte frames;
  // the widest limit admits the longest frame. Full 14-byte frames refresh every field.
  task automatic test_length_limits();
    logic [7:0] lim;
    write_length_limit(8'd0);
    send_rx_byte(8'd0);
    send_rx_byte(8'd1);
    send_rx_byte(8'h80);
    send_rx_byte(8'hFF);
    write_length_limit(8'd1);
    send_rx_byte(8'd1);
    send_rx_byte(8'd0);
    write_length_limit(8'd2);
    send_rx_byte(8'd2);
    send_random_frame(1, 1'b0);
    send_random_frame(1, 1'b1);
    write_length_limit(8'd255);
    send_random_frame(14, 1'b0);
    send_random_frame(13, 1'b0);
    send_random_frame(254, 1'b0);
    send_random_frame(14, 1'b1);
    lim = 8'($urandom_range(3, 254));
    write_length_limit(lim);
    send_rx_byte(lim);
    send_random_frame(int'(lim) - 1, 1'b0);
    settle_receiver();
  endtask

  // Mostly well-formed frames with random content under several limits, mixed with refused
  // lengths and raw noise bytes. Most frames are short; a few go up to the longest allowed length.
  task automatic test_random_frames(input int total_bytes);
    logic [7:0] limits[4];
    int         target;
    int         pick;
    int         longest;
    int         len;
    limits[0] = 8'd255;
    limits[1] = 8'($urandom_range(8, 254));
    limits[2] = 8'd24;
    limits[3] = 8'd255;
    foreach (limits[p]) begin
      write_length_limit(limits[p]);
      longest = int'(limits[p]) - 1;
      target  = n_bytes + total_bytes / 4;
      // The first phase opens with a stretch where neither side idles.
      if (p == 0) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      while (n_bytes < target) begin
        if (p == 0 && n_bytes > target - total_bytes / 4 + 60) begin
          tx_gaps = 1'b1;
          rx_gaps = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          if ($urandom_range(0, 99) < 90) len = $urandom_range(1, (longest < 20) ? longest : 20);
          else len = $urandom_range(1, longest);
          send_random_frame(len, $urandom_range(0, 99) < 20);
        end else if (pick < 90) begin
          send_rx_byte($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(limits[p], 255)));
        end else begin
          send_rx_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    settle_receiver();
  endtask

  // The result side holds off for a long stretch while refused lengths and frames keep
  // coming, so the block fills up and must stall its byte input.
  task automatic test_backpressure();
    int i;
    settle_receiver();
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 30; i++) send_rx_byte(8'd0);
    send_random_frame(3, 1'b0);
    send_random_frame(2, 1'b1);
    for (i = 0; i < 10; i++) send_rx_byte(8'hFF);
    tx_gaps = 1'b1;
    settle_receiver();
  endtask

  initial begin
    clear_receiver_model();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_length_limits();
    test_random_frames(260);
    test_backpressure();

    settle_receiver();
    $display("Covered %0d bytes under %0d limit settings: %0d good frames, %0d CRC errors,",
             n_bytes, n_limits, n_good, n_crc_bad);
    $display("%0d refused lengths; %0d result words checked, %0d field errors.",
             n_rejected, n_checked, errors);
    if (errors == 0 && pending_words_q.size() == 0) begin
      $display("radio_frame_receiver_crc_check: match");
    end else begin
      $display("radio_frame_receiver_crc_check: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Timeout with %0d result words still owed.", pending_words_q.size());
    $display("radio_frame_receiver_crc_check: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/rfr_pkg.sv
hw/rtl/rfr_rx_if.sv
hw/rtl/rfr_res_if.sv
hw/rtl/rfr_frame_parser.sv
hw/rtl/rfr_result_reg.sv
hw/rtl/radio_frame_receiver_crc_check.sv
tb/tb_top.sv
